// ===== hw/rtl/istft_ola_pkg.sv =====
// ----------------------------------------------------------------------------
// istft_ola_pkg
// Shared types, constants and state codes of the ISTFT overlap-add stage.
// ----------------------------------------------------------------------------
package istft_ola_pkg;

    // Field widths (Q1.15 samples, Q0.16 window, Q9.15 ring, Q4.16 power)
    localparam int SMP_W = 16;
    localparam int WIN_W = 16;
    localparam int ACC_W = 24;
    localparam int PWR_W = 20;
    localparam int QUO_W = 17;
    localparam int CFG_W = 12;

    localparam int FRAME_SIZE_DEF    = 2048;
    localparam int WINDOW_LENGTH_DEF = 1102;

    localparam logic [CFG_W-1:0] HOP_RESET = 12'd275;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sh800000;
    localparam logic [PWR_W-1:0]        PWR_MAX = 20'hFFFFF;
    localparam logic [QUO_W-1:0]        QUO_CAP = 17'd65536;

    typedef struct packed {
        logic signed [SMP_W-1:0] frame_sample;
        logic                    last_frame;
    } in_beat_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_sample;
        logic                    clipped;
    } out_beat_t;

    // Request to the iterative divider
    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] mag;
        logic [PWR_W-1:0] divisor;
    } div_req_t;

    // Answer of the iterative divider
    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } ola_state_t;

endpackage

// ===== hw/rtl/istft_ola_rom.sv =====
// ----------------------------------------------------------------------------
// istft_ola_rom
// Center-padded Hann window ROM, Q0.16, registered read.
// ----------------------------------------------------------------------------
module istft_ola_rom #(
    parameter int FRAME_SIZE    = istft_ola_pkg::FRAME_SIZE_DEF,
    parameter int WINDOW_LENGTH = istft_ola_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rd_en,
    input  logic [$clog2(FRAME_SIZE)-1:0]        addr,
    output logic [istft_ola_pkg::WIN_W-1:0]      win
);
    import istft_ola_pkg::*;

    localparam int WIN_LEN = (WINDOW_LENGTH < FRAME_SIZE) ? WINDOW_LENGTH : FRAME_SIZE;
    localparam int WIN_DIV = (WIN_LEN > 1) ? WIN_LEN - 1 : 1;
    localparam int LPAD    = (FRAME_SIZE - WIN_LEN) / 2;

    typedef logic [WIN_W-1:0] rom_t [FRAME_SIZE];

    // sin^2 through a Q30 Taylor series, evaluated at elaboration
    function automatic rom_t build_rom();
        rom_t            tbl;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned r;
        longint unsigned s;
        longint unsigned s2;
        longint unsigned w;
        longint unsigned one;
        int              k;
        int              m;
        one = 64'd1 << 30;
        for (int p = 0; p < FRAME_SIZE; p++)
        begin
            if (WIN_LEN < 2 || p < LPAD || p - LPAD >= WIN_LEN)
            begin
                tbl[p] = '0;
            end
            else
            begin
                k  = p - LPAD;
                m  = (k < WIN_LEN - 1 - k) ? k : WIN_LEN - 1 - k;
                a  = (64'd3373259426 * longint'(m)) / WIN_DIV;
                a2 = (a * a) >> 30;
                r  = one;
                r  = one - ((a2 * r) >> 30) / 110;
                r  = one - ((a2 * r) >> 30) / 72;
                r  = one - ((a2 * r) >> 30) / 42;
                r  = one - ((a2 * r) >> 30) / 20;
                r  = one - ((a2 * r) >> 30) / 6;
                s  = (a * r) >> 30;
                if (s > one)
                begin
                    s = one;
                end
                s2 = (s * s) >> 30;
                w  = (s2 + 64'd8192) >> 14;
                if (w > 64'd65535)
                begin
                    w = 64'd65535;
                end
                tbl[p] = w[WIN_W-1:0];
            end
        end
        return tbl;
    endfunction

    localparam rom_t HANN_ROM = build_rom();

    logic [WIN_W-1:0] win_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            win_reg <= HANN_ROM[addr];
        end
    end

    assign win = win_reg;

endmodule

// ===== hw/rtl/istft_ola_ring.sv =====
// ----------------------------------------------------------------------------
// istft_ola_ring
// Overlap and window-power rings: one write and one registered read port.
// ----------------------------------------------------------------------------
module istft_ola_ring #(
    parameter int FRAME_SIZE = istft_ola_pkg::FRAME_SIZE_DEF
) (
    input  logic                                      clk,
    input  logic                                      rd_en,
    input  logic [$clog2(FRAME_SIZE)-1:0]             rd_addr,
    output logic signed [istft_ola_pkg::ACC_W-1:0]    rd_acc,
    output logic [istft_ola_pkg::PWR_W-1:0]           rd_pwr,
    input  logic                                      wr_en,
    input  logic [$clog2(FRAME_SIZE)-1:0]             wr_addr,
    input  logic signed [istft_ola_pkg::ACC_W-1:0]    wr_acc,
    input  logic [istft_ola_pkg::PWR_W-1:0]           wr_pwr
);
    import istft_ola_pkg::*;

    logic signed [ACC_W-1:0] acc_mem [FRAME_SIZE];
    logic [PWR_W-1:0]        pwr_mem [FRAME_SIZE];
    logic signed [ACC_W-1:0] rd_acc_reg;
    logic [PWR_W-1:0]        rd_pwr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_acc;
            pwr_mem[wr_addr] <= wr_pwr;
        end
        if (rd_en)
        begin
            rd_acc_reg <= acc_mem[rd_addr];
            rd_pwr_reg <= pwr_mem[rd_addr];
        end
    end

    assign rd_acc = rd_acc_reg;
    assign rd_pwr = rd_pwr_reg;

endmodule

// ===== hw/rtl/istft_ola_div.sv =====
// ----------------------------------------------------------------------------
// istft_ola_div
// Restoring divider: (mag << 16) / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module istft_ola_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  istft_ola_pkg::div_req_t req,
    output istft_ola_pkg::div_rsp_t rsp
);
    import istft_ola_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PWR_W-1:0] rem_reg;
    logic [PWR_W-1:0] div_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             bit_reg;
    logic             sat_reg;
    logic             sat_w;
    logic [PWR_W+1:0] trial;

    // quotient of 2^17 or more only saturates, so skip straight to the cap
    assign sat_w = req.mag >= ACC_W'({req.divisor, 1'b0});
    assign trial = {1'b0, rem_reg, bit_reg} - {2'b00, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.divisor;
            sat_reg <= sat_w;
            rem_reg <= sat_w ? '0 : req.mag[PWR_W:1];
            bit_reg <= req.mag[0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            bit_reg <= 1'b0;
            if (!trial[PWR_W+1])
            begin
                rem_reg <= trial[PWR_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[PWR_W-2:0], bit_reg};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = quo_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUO_W))
        else $error("divider step count out of range");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg && !busy_reg)
        else $error("divider done held or busy after finish");

endmodule

// ===== hw/rtl/istft_overlap_add_synthesis.sv =====
// ----------------------------------------------------------------------------
// istft_overlap_add_synthesis
// Weighted overlap-add of inverse-FFT frames with Hann window normalization.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | sink      | in_valid / in_stall   | frame_sample, last_frame
//   out     | source    | out_valid / out_stall | out_sample, clipped
//   cfg     | sink      | cfg_we                | cfg_data = hop size
//
// One sample is in flight at a time. A sample that stays in the rings or is
// trimmed passes through the read, multiply and accumulate states and back to
// idle; one that is emitted with zero window power goes on to the result
// state; one that is divided first waits in the divide state for the 17
// one-bit steps of the restoring divider. After reset the rings are swept to
// zero, one entry a cycle, and in_stall stays high meanwhile; cfg writes are
// taken any time. A result waits in the output register while the next sample
// is accepted; only a second result waits for the output beat to drain.
//
module istft_overlap_add_synthesis #(
    parameter int FRAME_SIZE    = istft_ola_pkg::FRAME_SIZE_DEF,
    parameter int WINDOW_LENGTH = istft_ola_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  istft_ola_pkg::in_beat_t             in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output istft_ola_pkg::out_beat_t            out_data,
    input  logic                                cfg_we,
    input  logic [istft_ola_pkg::CFG_W-1:0]     cfg_data
);
    import istft_ola_pkg::*;

    localparam int IDX_W      = $clog2(FRAME_SIZE);
    localparam int CNT_W      = $clog2(FRAME_SIZE + 1);
    localparam int HW         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int HALF       = FRAME_SIZE / 2;
    localparam int TRIM_W     = $clog2(HALF + 1);
    localparam int TAIL_START = FRAME_SIZE - HALF;
    localparam int HOP_QTR    = WINDOW_LENGTH / 4;
    localparam int HOP_ZERO   = (HOP_QTR == 0) ? 1 : HOP_QTR;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ola_state_t              state_reg, state_next;
    logic [CFG_W-1:0]        hop_reg;
    logic [IDX_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]        frame_pos_reg, frame_pos_next;
    logic [IDX_W-1:0]        ring_base_reg, ring_base_next;
    logic [TRIM_W-1:0]       trim_reg, trim_next;
    logic                    out_valid_reg, out_valid_next;

    // per-sample payload
    logic signed [SMP_W-1:0] smp_reg, smp_next;
    logic                    last_reg, last_next;
    logic [IDX_W-1:0]        p_reg, p_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [32:0]      prod_reg, prod_next;
    logic [WIN_W-1:0]        pw_reg, pw_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [PWR_W-1:0]        pwr_reg, pwr_next;
    out_beat_t               out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Submodule wiring
    // ------------------------------------------------------------------
    logic                    rom_rd_en;
    logic [WIN_W-1:0]        rom_win;
    logic                    ring_rd_en;
    logic signed [ACC_W-1:0] ring_rd_acc;
    logic [PWR_W-1:0]        ring_rd_pwr;
    logic                    ring_wr_en;
    logic [IDX_W-1:0]        ring_wr_addr;
    logic signed [ACC_W-1:0] ring_wr_acc;
    logic [PWR_W-1:0]        ring_wr_pwr;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [HW-1:0]           hop_raw;
    logic [HW-1:0]           hop_eff;
    logic [IDX_W:0]          idx_sum;
    logic [HW:0]             base_sum;
    logic                    is_final;
    logic                    p_last;
    logic                    emit;
    logic signed [33:0]      rnd;
    logic signed [17:0]      contrib;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic [PWR_W:0]          pwr_sum;
    logic [PWR_W-1:0]        pwr_sat;
    logic [31:0]             wsq;
    logic [QUO_W-1:0]        quo_cap;
    logic                    clip_w;
    logic [SMP_W-1:0]        val_w;

    // Hop of zero falls back to a quarter window; clamp to the frame size.
    assign hop_raw = (hop_reg == '0) ? HW'(HOP_ZERO) : HW'(hop_reg);
    assign hop_eff = (hop_raw > HW'(FRAME_SIZE)) ? HW'(FRAME_SIZE) : hop_raw;

    // Ring index of the incoming position: one compare-subtract wrap.
    assign idx_sum = {1'b0, ring_base_reg} + {1'b0, frame_pos_reg};

    // Next frame starts one hop further round the ring.
    assign base_sum = (HW+1)'(ring_base_reg) + (HW+1)'(hop_eff);

    // Final once no later frame reaches this position.
    assign is_final = last_reg || (HW'(p_reg) < hop_eff);
    assign p_last   = (p_reg == IDX_W'(FRAME_SIZE - 1));
    assign emit     = is_final && !(trim_reg < TRIM_W'(HALF))
                      && (!last_reg || (p_reg < IDX_W'(TAIL_START)));

    // Round the windowed product half up to Q1.15 and accumulate.
    assign rnd     = 34'(prod_reg) + 34'sd32768;
    assign contrib = rnd[33:16];
    assign acc_sum = (ACC_W+1)'(ring_rd_acc) + (ACC_W+1)'(contrib);
    assign pwr_sum = {1'b0, ring_rd_pwr} + (PWR_W+1)'(pw_reg);
    assign wsq     = 32'(rom_win) * 32'(rom_win);

    always_comb
    begin
        if (acc_sum > (ACC_W+1)'(ACC_MAX))
        begin
            acc_sat = ACC_MAX;
        end
        else if (acc_sum < (ACC_W+1)'(ACC_MIN))
        begin
            acc_sat = ACC_MIN;
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        pwr_sat = pwr_sum[PWR_W] ? PWR_MAX : pwr_sum[PWR_W-1:0];
    end

    // Output formatting: cap the quotient, restore sign, saturate to 16 bits; with zero window power, saturate the sum.
    always_comb
    begin
        quo_cap = (div_rsp.sat || div_rsp.quo > QUO_CAP) ? QUO_CAP : div_rsp.quo;
        if (pwr_reg == '0)
        begin
            clip_w = (acc_reg > ACC_W'(32767)) || (acc_reg < -ACC_W'(32768));
            if (acc_reg > ACC_W'(32767))
            begin
                val_w = 16'h7FFF;
            end
            else if (acc_reg < -ACC_W'(32768))
            begin
                val_w = 16'h8000;
            end
            else
            begin
                val_w = acc_reg[SMP_W-1:0];
            end
        end
        else if (!acc_reg[ACC_W-1])
        begin
            clip_w = quo_cap > QUO_W'(32767);
            val_w  = clip_w ? 16'h7FFF : quo_cap[SMP_W-1:0];
        end
        else
        begin
            clip_w = quo_cap > QUO_W'(32768);
            val_w  = clip_w ? 16'h8000 : (~quo_cap[SMP_W-1:0] + 16'd1);
        end
    end

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        frame_pos_next = frame_pos_reg;
        ring_base_next = ring_base_reg;
        trim_next      = trim_reg;
        out_valid_next = out_valid_reg;
        smp_next       = smp_reg;
        last_next      = last_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        pw_next        = pw_reg;
        acc_next       = acc_reg;
        pwr_next       = pwr_reg;
        out_data_next  = out_data_reg;
        in_stall       = 1'b1;
        rom_rd_en      = 1'b0;
        ring_rd_en     = 1'b0;
        ring_wr_en     = 1'b0;
        ring_wr_addr   = idx_reg;
        ring_wr_acc    = '0;
        ring_wr_pwr    = '0;
        div_req.start  = 1'b0;
        div_req.mag    = acc_sat[ACC_W-1] ? ACC_W'(-acc_sat) : ACC_W'(acc_sat);
        div_req.divisor = pwr_sat;

        // drain the output register when the sink takes the beat
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero both rings one entry a cycle
                ring_wr_en    = 1'b1;
                ring_wr_addr  = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(FRAME_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    smp_next   = in_data.frame_sample;
                    last_next  = in_data.last_frame;
                    p_next     = frame_pos_reg;
                    idx_next   = (idx_sum >= (IDX_W+1)'(FRAME_SIZE))
                                 ? IDX_W'(idx_sum - (IDX_W+1)'(FRAME_SIZE))
                                 : IDX_W'(idx_sum);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rom_rd_en  = 1'b1;
                ring_rd_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = 33'(smp_reg) * 33'($signed({1'b0, rom_win}));
                pw_next    = 16'((wsq + 32'd32768) >> 16);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // write back: clear a final entry, else keep the new sums
                ring_wr_en  = 1'b1;
                ring_wr_acc = is_final ? '0 : acc_sat;
                ring_wr_pwr = is_final ? '0 : pwr_sat;
                acc_next    = acc_sat;
                pwr_next    = pwr_sat;
                if (is_final && (trim_reg < TRIM_W'(HALF)))
                begin
                    trim_next = trim_reg + TRIM_W'(1);
                end
                if (p_last)
                begin
                    frame_pos_next = '0;
                    if (last_reg)
                    begin
                        ring_base_next = '0;
                        trim_next      = '0;
                    end
                    else
                    begin
                        ring_base_next = (base_sum >= (HW+1)'(FRAME_SIZE))
                                         ? IDX_W'(base_sum - (HW+1)'(FRAME_SIZE))
                                         : IDX_W'(base_sum);
                    end
                end
                else
                begin
                    frame_pos_next = p_reg + IDX_W'(1);
                end
                if (!emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (pwr_sat != '0)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.out_sample = val_w;
                    out_data_next.clipped    = clip_w;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hop_reg       <= HOP_RESET;
            clr_addr_reg  <= '0;
            frame_pos_reg <= '0;
            ring_base_reg <= '0;
            trim_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            frame_pos_reg <= frame_pos_next;
            ring_base_reg <= ring_base_next;
            trim_reg      <= trim_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                hop_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        last_reg     <= last_next;
        p_reg        <= p_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        pw_reg       <= pw_next;
        acc_reg      <= acc_next;
        pwr_reg      <= pwr_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    istft_ola_rom #(
        .FRAME_SIZE    (FRAME_SIZE),
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_rom (
        .clk   (clk),
        .rd_en (rom_rd_en),
        .addr  (p_reg),
        .win   (rom_win)
    );

    istft_ola_ring #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_ring (
        .clk     (clk),
        .rd_en   (ring_rd_en),
        .rd_addr (idx_reg),
        .rd_acc  (ring_rd_acc),
        .rd_pwr  (ring_rd_pwr),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_acc  (ring_wr_acc),
        .wr_pwr  (ring_wr_pwr)
    );

    istft_ola_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_addr_reg == IDX_W'(FRAME_SIZE - 1))
        |=> state_reg == ST_IDLE)
        else $error("ring clear sweep did not end at the last entry");

    a_trim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        trim_reg <= TRIM_W'(HALF))
        else $error("head trim count beyond half frame");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output beat loaded outside the result state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> div_req.divisor != '0)
        else $error("divider started with zero window power");

endmodule
